[hdl/lav_pkg.sv]
// shared constants and types for the look-at view matrix block
// no dependencies; imported by every module of the block
`timescale 1ns / 1ps
`default_nettype none
package lav_pkg;

  // the largest normalised magnitude lies in [2^(NORM_TOP-1), 2^NORM_TOP)
  localparam int NORM_TOP   = 30;
  localparam int ROOT_BITS  = NORM_TOP + 1;
  localparam int SQ_WIDTH   = 2 * NORM_TOP + 2;

  typedef logic [1:0] row_t;

  localparam row_t ROW_X = 2'd0;
  localparam row_t ROW_Y = 2'd1;
  localparam row_t ROW_Z = 2'd2;

endpackage
`default_nettype wire

[hdl/lav_norm.sv]
// pipelined vector normaliser: magnitude scaling, square root, three dividers
// depends on lav_pkg; one step of root or quotient per stage, side data rides along
`timescale 1ns / 1ps
`default_nettype none
module lav_norm #(
  parameter int SW        = 32,
  parameter int FRAC_BITS = 16,
  parameter int PW        = 32
) (
  input  wire                        clk,
  input  wire                        rst_n,
  input  wire                        adv,
  input  wire                        in_valid,
  input  wire  [SW-1:0]              in_c0,
  input  wire  [SW-1:0]              in_c1,
  input  wire  [SW-1:0]              in_c2,
  input  wire  [PW-1:0]              in_side,
  output logic                       out_valid,
  output logic signed [FRAC_BITS+1:0] out_u0,
  output logic signed [FRAC_BITS+1:0] out_u1,
  output logic signed [FRAC_BITS+1:0] out_u2,
  output logic [PW-1:0]              out_side
);
  import lav_pkg::*;

  localparam int F      = FRAC_BITS;
  localparam int UW     = F + 2;
  localparam int EW     = SW + NORM_TOP;
  localparam int SHB    = $clog2(EW);
  localparam int NW     = F + NORM_TOP + 2;
  localparam int DW     = ROOT_BITS + 1;
  localparam int L_PREP = ROOT_BITS + 5;
  localparam int L_OUT  = L_PREP + F + 2;

  logic [SW-1:0] c [3];
  logic [SW-1:0] m_nxt [3];
  logic [2:0]    neg_nxt;

  logic [L_OUT:0]      v_r;
  logic [L_OUT-1:0]    zero_r;
  logic [2:0]          neg_r [0:L_OUT-1];
  logic [PW-1:0]       side_r [0:L_OUT];

  logic [SW-1:0]       m0_r [3];
  logic [SW-1:0]       m1_r [3];
  logic [SW-1:0]       orv_r;
  logic                rgt_r;
  logic [SHB-1:0]      sh_r;
  logic                rgt_nxt;
  logic [SHB-1:0]      sh_nxt;
  logic [SHB-1:0]      msb;
  logic [EW-1:0]       shf [3];

  logic [NORM_TOP-1:0]   mn_r [2:L_PREP-1][3];
  logic [2*NORM_TOP-1:0] sq_r [3];
  logic [SQ_WIDTH-1:0]   sr_r [0:ROOT_BITS-1];
  logic [ROOT_BITS-1:0]  rt_r [0:ROOT_BITS];
  logic [NW-1:0]         rem_r [0:F][3];
  logic [F:0]            q_r [0:F+1][3];
  logic [DW-1:0]         dd_r [0:F];
  logic signed [UW-1:0]  u_r [3];

  assign c[0] = in_c0;
  assign c[1] = in_c1;
  assign c[2] = in_c2;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      neg_nxt[i] = c[i][SW-1];
      m_nxt[i]   = neg_nxt[i] ? (~c[i] + SW'(1)) : c[i];
    end
  end

  // leading one of the or of all magnitudes equals that of the largest one
  always_comb begin
    msb = '0;
    for (int b = 0; b < SW; b++) begin
      if (orv_r[b]) begin
        msb = SHB'(b);
      end
    end
    rgt_nxt = msb > SHB'(NORM_TOP - 1);
    sh_nxt  = rgt_nxt ? (msb - SHB'(NORM_TOP - 1)) : (SHB'(NORM_TOP - 1) - msb);
  end

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      shf[i] = rgt_r ? (EW'(m1_r[i]) >> sh_r) : (EW'(m1_r[i]) << sh_r);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (adv) begin
      v_r <= {v_r[L_OUT-1:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      neg_r[0]  <= neg_nxt;
      zero_r[0] <= ~|(m_nxt[0] | m_nxt[1] | m_nxt[2]);
      side_r[0] <= in_side;
      for (int k = 1; k < L_OUT; k++) begin
        neg_r[k]  <= neg_r[k-1];
        zero_r[k] <= zero_r[k-1];
      end
      for (int k = 1; k <= L_OUT; k++) begin
        side_r[k] <= side_r[k-1];
      end
    end
  end

  // scaling, squares and sum
  always_ff @(posedge clk) begin
    if (adv) begin
      orv_r <= m_nxt[0] | m_nxt[1] | m_nxt[2];
      rgt_r <= rgt_nxt;
      sh_r  <= sh_nxt;
      for (int i = 0; i < 3; i++) begin
        m0_r[i]    <= m_nxt[i];
        m1_r[i]    <= m0_r[i];
        mn_r[2][i] <= shf[i][NORM_TOP-1:0];
        sq_r[i]    <= mn_r[2][i] * mn_r[2][i];
      end
      for (int k = 3; k < L_PREP; k++) begin
        mn_r[k] <= mn_r[k-1];
      end
      sr_r[0] <= SQ_WIDTH'(sq_r[0]) + SQ_WIDTH'(sq_r[1]) + SQ_WIDTH'(sq_r[2]);
      rt_r[0] <= '0;
    end
  end

  // square root, one result bit per stage
  genvar j;
  for (j = 1; j <= ROOT_BITS; j++) begin : g_sqrt
    localparam int BI = ROOT_BITS - j;
    logic [SQ_WIDTH:0] tr;
    logic              take;

    assign tr   = ((SQ_WIDTH+1)'(rt_r[j-1]) << (BI + 1)) | ((SQ_WIDTH+1)'(1) << (2 * BI));
    assign take = (SQ_WIDTH+1)'(sr_r[j-1]) >= tr;

    always_ff @(posedge clk) begin
      if (adv) begin
        rt_r[j] <= take ? (rt_r[j-1] | (ROOT_BITS'(1) << BI)) : rt_r[j-1];
      end
    end

    if (j < ROOT_BITS) begin : g_rem
      always_ff @(posedge clk) begin
        if (adv) begin
          sr_r[j] <= take ? (sr_r[j-1] - tr[SQ_WIDTH-1:0]) : sr_r[j-1];
        end
      end
    end
  end

  // rounded quotient set-up: (m * 2^(F+1) + len) / (2 * len)
  always_ff @(posedge clk) begin
    if (adv) begin
      dd_r[0] <= {rt_r[ROOT_BITS], 1'b0};
      for (int i = 0; i < 3; i++) begin
        rem_r[0][i] <= (NW'(mn_r[L_PREP-1][i]) << (F + 1)) + NW'(rt_r[ROOT_BITS]);
        q_r[0][i]   <= '0;
      end
    end
  end

  for (j = 1; j <= F + 1; j++) begin : g_div
    localparam int BI = F + 1 - j;
    logic [NW-1:0] dsh;
    logic [2:0]    take;

    assign dsh = NW'(dd_r[j-1]) << BI;

    always_comb begin
      for (int i = 0; i < 3; i++) begin
        take[i] = rem_r[j-1][i] >= dsh;
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        for (int i = 0; i < 3; i++) begin
          q_r[j][i] <= take[i] ? (q_r[j-1][i] | ((F+1)'(1) << BI)) : q_r[j-1][i];
        end
      end
    end

    if (j <= F) begin : g_rem
      always_ff @(posedge clk) begin
        if (adv) begin
          dd_r[j] <= dd_r[j-1];
          for (int i = 0; i < 3; i++) begin
            rem_r[j][i] <= take[i] ? (rem_r[j-1][i] - dsh) : rem_r[j-1][i];
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 0; i < 3; i++) begin
        if (zero_r[L_OUT-1]) begin
          u_r[i] <= '0;
        end else if (neg_r[L_OUT-1][i]) begin
          u_r[i] <= -UW'({1'b0, q_r[F+1][i]});
        end else begin
          u_r[i] <= UW'({1'b0, q_r[F+1][i]});
        end
      end
    end
  end

  assign out_valid = v_r[L_OUT];
  assign out_u0    = u_r[0];
  assign out_u1    = u_r[1];
  assign out_u2    = u_r[2];
  assign out_side  = side_r[L_OUT];

endmodule
`default_nettype wire

[hdl/lav_rows.sv]
// row sender: holds one finished matrix and hands out its three rows in order
// depends on lav_pkg; acts as the output register of the block
`timescale 1ns / 1ps
`default_nettype none
module lav_rows #(
  parameter int COORD_WIDTH = 32,
  parameter int FRAC_BITS   = 16,
  parameter int OUT_DW      = 88
) (
  input  wire                           clk,
  input  wire                           rst_n,
  input  wire                           item_valid,
  output logic                          item_ready,
  input  wire signed [FRAC_BITS+1:0]    item_axis [3][3],
  input  wire signed [COORD_WIDTH-1:0]  item_col3 [3],
  output logic                          out_tvalid,
  input  wire                           out_tready,
  output logic [OUT_DW-1:0]             out_tdata,
  output logic                          out_tlast,
  output logic [1:0]                    out_tuser
);
  import lav_pkg::*;

  localparam int UW = FRAC_BITS + 2;

  logic                        busy_r;
  row_t                        cnt_r;
  logic signed [UW-1:0]        ax_r [3][3];
  logic signed [COORD_WIDTH-1:0] c3_r [3];
  logic                        take;
  logic [UW-1:0]               s0, s1, s2;
  logic [COORD_WIDTH-1:0]      s3;

  assign item_ready = !busy_r || (out_tready && cnt_r == ROW_Z);
  assign take       = item_valid && item_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= ROW_X;
    end else if (take) begin
      busy_r <= 1'b1;
      cnt_r  <= ROW_X;
    end else if (busy_r && out_tready) begin
      if (cnt_r == ROW_Z) begin
        busy_r <= 1'b0;
      end else begin
        cnt_r <= cnt_r + 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      ax_r <= item_axis;
      c3_r <= item_col3;
    end
  end

  always_comb begin
    case (cnt_r)
      ROW_X: begin
        s0 = ax_r[0][0]; s1 = ax_r[0][1]; s2 = ax_r[0][2]; s3 = c3_r[0];
      end
      ROW_Y: begin
        s0 = ax_r[1][0]; s1 = ax_r[1][1]; s2 = ax_r[1][2]; s3 = c3_r[1];
      end
      default: begin
        s0 = ax_r[2][0]; s1 = ax_r[2][1]; s2 = ax_r[2][2]; s3 = c3_r[2];
      end
    endcase
  end

  assign out_tvalid = busy_r;
  assign out_tuser  = cnt_r;
  assign out_tlast  = cnt_r == ROW_Z;
  assign out_tdata  = OUT_DW'({s3, s2, s1, s0});

endmodule
`default_nettype wire

[hdl/look_at_view_matrix.sv]
// top level of the look-at view matrix block
// depends on lav_pkg, lav_norm and lav_rows
//
// usage:
//   in_*  : one item per handshake, nine signed coordinates (position, target,
//           up), FRAC_BITS fraction bits each
//   out_* : three items per input, rows right, up and view; tuser carries the
//           row index and tlast marks the view row
//   the path from input accept to the first row runs through the two
//   normalisers in series (z beside up, then x; one root bit and one
//   quotient bit per stage) and the input, cross, dot and row stages
//   throughput is bounded by the single result channel, which sends three
//   rows per input item; new inputs enter the pipeline while earlier matrices
//   are still in flight, whenever the last stage is not holding a finished one
//   reset clears all valid bits; no pipeline contents survive it
//   when the receiver stalls, the whole pipeline holds in place and in_tready
//   falls once the last stage holds a finished matrix; nothing is lost
`timescale 1ns / 1ps
`default_nettype none
module look_at_view_matrix #(
  parameter int COORD_WIDTH = 32,
  parameter int FRAC_BITS   = 16
) (
  input  wire                                       clk,
  input  wire                                       rst_n,
  input  wire                                       in_tvalid,
  output logic                                      in_tready,
  // pos_x, pos_y, pos_z, aim_x, aim_y, aim_z, up_x, up_y, up_z
  input  wire  [((9*COORD_WIDTH+7)/8)*8-1:0]        in_tdata,
  output logic                                      out_tvalid,
  input  wire                                       out_tready,
  // col0, col1, col2, col3
  output logic [((3*(FRAC_BITS+2)+COORD_WIDTH+7)/8)*8-1:0] out_tdata,
  output logic                                      out_tlast,
  // row_index
  output logic [1:0]                                out_tuser
);
  import lav_pkg::*;

  localparam int W      = COORD_WIDTH;
  localparam int F      = FRAC_BITS;
  localparam int UW     = F + 2;
  localparam int XW     = 2 * F + 3;
  localparam int OUT_DW = ((3 * UW + W + 7) / 8) * 8;

  function automatic logic signed [W-1:0] sat_w(input logic signed [W+3:0] s);
    logic fits;
    fits = (s[W+3:W-1] == '0) || (s[W+3:W-1] == '1);
    if (fits) begin
      sat_w = s[W-1:0];
    end else if (s[W+3]) begin
      sat_w = {1'b1, {(W-1){1'b0}}};
    end else begin
      sat_w = {1'b0, {(W-1){1'b1}}};
    end
  endfunction

  // round(a * p / 2^F), half away from zero
  function automatic logic signed [W+1:0] sprod(input logic signed [UW-1:0] a,
                                                input logic signed [W-1:0] p);
    logic [UW-1:0]  ma;
    logic [W-1:0]   mp;
    logic [F+W:0]   pr;
    logic [W:0]     r;
    ma = a[UW-1] ? -a : a;
    mp = p[W-1] ? -p : p;
    pr = (F+W+1)'(ma[F:0]) * (F+W+1)'(mp);
    r  = (W+1)'((pr + ((F+W+1)'(1) << (F - 1))) >> F);
    sprod = (a[UW-1] != p[W-1]) ? -(W+2)'(r) : (W+2)'(r);
  endfunction

  function automatic logic signed [UW-1:0] rnd_unit(input logic signed [2*UW-1:0] t);
    logic [2*UW-1:0] mg;
    logic [2*UW-1:0] r;
    mg = t[2*UW-1] ? -t : t;
    r  = (mg + ((2*UW)'(1) << (F - 1))) >> F;
    if (r > ((2*UW)'(1) << F)) begin
      r = (2*UW)'(1) << F;
    end
    rnd_unit = t[2*UW-1] ? -UW'(r) : UW'(r);
  endfunction

  logic adv;
  logic item_ready;

  // input stage
  logic signed [W-1:0] pos_in [3];
  logic signed [W-1:0] aim_in [3];
  logic signed [W-1:0] up_in [3];
  logic                t0_v_r;
  logic signed [W-1:0] t0_pos_r [3];
  logic signed [W-1:0] t0_d_r [3];
  logic signed [W-1:0] t0_up_r [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      pos_in[i] = in_tdata[i*W +: W];
      aim_in[i] = in_tdata[(3+i)*W +: W];
      up_in[i]  = in_tdata[(6+i)*W +: W];
    end
  end

  assign in_tready = adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      t0_v_r <= 1'b0;
    end else if (adv) begin
      t0_v_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 0; i < 3; i++) begin
        t0_pos_r[i] <= pos_in[i];
        t0_up_r[i]  <= up_in[i];
        t0_d_r[i]   <= sat_w((W+4)'(pos_in[i]) - (W+4)'(aim_in[i]));
      end
    end
  end

  // z axis and unit up, side by side
  logic                 nz_v, nu_v;
  logic signed [UW-1:0] nz_u [3];
  logic signed [UW-1:0] nu_u [3];
  logic [2*W-1:0]       nz_side;
  logic [W-1:0]         nu_side;

  lav_norm #(.SW(W), .FRAC_BITS(F), .PW(2*W)) u_norm_z (
    .clk(clk), .rst_n(rst_n), .adv(adv), .in_valid(t0_v_r),
    .in_c0(t0_d_r[0]), .in_c1(t0_d_r[1]), .in_c2(t0_d_r[2]),
    .in_side({t0_pos_r[1], t0_pos_r[0]}),
    .out_valid(nz_v), .out_u0(nz_u[0]), .out_u1(nz_u[1]), .out_u2(nz_u[2]),
    .out_side(nz_side)
  );

  lav_norm #(.SW(W), .FRAC_BITS(F), .PW(W)) u_norm_up (
    .clk(clk), .rst_n(rst_n), .adv(adv), .in_valid(t0_v_r),
    .in_c0(t0_up_r[0]), .in_c1(t0_up_r[1]), .in_c2(t0_up_r[2]),
    .in_side(t0_pos_r[2]),
    .out_valid(nu_v), .out_u0(nu_u[0]), .out_u1(nu_u[1]), .out_u2(nu_u[2]),
    .out_side(nu_side)
  );

  // cross(up, z): products, then differences
  logic                   c1_v_r, c2_v_r;
  logic signed [2*UW-1:0] c1_p_r [6];
  logic signed [UW-1:0]   c1_z_r [3];
  logic signed [W-1:0]    c1_pos_r [3];
  logic signed [XW-1:0]   c2_x_r [3];
  logic signed [UW-1:0]   c2_z_r [3];
  logic signed [W-1:0]    c2_pos_r [3];
  logic signed [2*UW-1:0] c2_dif [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      c2_dif[i] = c1_p_r[2*i] - c1_p_r[2*i+1];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      c1_p_r[0] <= nu_u[1] * nz_u[2];
      c1_p_r[1] <= nu_u[2] * nz_u[1];
      c1_p_r[2] <= nu_u[2] * nz_u[0];
      c1_p_r[3] <= nu_u[0] * nz_u[2];
      c1_p_r[4] <= nu_u[0] * nz_u[1];
      c1_p_r[5] <= nu_u[1] * nz_u[0];
      c1_z_r      <= nz_u;
      c1_pos_r[0] <= nz_side[W-1:0];
      c1_pos_r[1] <= nz_side[2*W-1:W];
      c1_pos_r[2] <= nu_side;
      for (int i = 0; i < 3; i++) begin
        c2_x_r[i] <= c2_dif[i][XW-1:0];
      end
      c2_z_r   <= c1_z_r;
      c2_pos_r <= c1_pos_r;
    end
  end

  // x axis
  logic                 nx_v;
  logic signed [UW-1:0] nx_u [3];
  logic [3*UW+3*W-1:0]  nx_side;
  logic signed [UW-1:0] nx_z [3];
  logic signed [W-1:0]  nx_pos [3];

  lav_norm #(.SW(XW), .FRAC_BITS(F), .PW(3*UW+3*W)) u_norm_x (
    .clk(clk), .rst_n(rst_n), .adv(adv), .in_valid(c2_v_r),
    .in_c0(c2_x_r[0]), .in_c1(c2_x_r[1]), .in_c2(c2_x_r[2]),
    .in_side({c2_z_r[2], c2_z_r[1], c2_z_r[0], c2_pos_r[2], c2_pos_r[1], c2_pos_r[0]}),
    .out_valid(nx_v), .out_u0(nx_u[0]), .out_u1(nx_u[1]), .out_u2(nx_u[2]),
    .out_side(nx_side)
  );

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      nx_pos[i] = nx_side[i*W +: W];
      nx_z[i]   = nx_side[3*W + i*UW +: UW];
    end
  end

  // y axis = cross(z, x), rounded back to unit scale
  logic                   y1_v_r, y2_v_r;
  logic signed [2*UW-1:0] y1_p_r [6];
  logic signed [UW-1:0]   y1_x_r [3];
  logic signed [UW-1:0]   y1_z_r [3];
  logic signed [W-1:0]    y1_pos_r [3];
  logic signed [UW-1:0]   y2_ax_r [3][3];
  logic signed [W-1:0]    y2_pos_r [3];

  always_ff @(posedge clk) begin
    if (adv) begin
      y1_p_r[0] <= nx_z[1] * nx_u[2];
      y1_p_r[1] <= nx_z[2] * nx_u[1];
      y1_p_r[2] <= nx_z[2] * nx_u[0];
      y1_p_r[3] <= nx_z[0] * nx_u[2];
      y1_p_r[4] <= nx_z[0] * nx_u[1];
      y1_p_r[5] <= nx_z[1] * nx_u[0];
      y1_x_r   <= nx_u;
      y1_z_r   <= nx_z;
      y1_pos_r <= nx_pos;
      for (int i = 0; i < 3; i++) begin
        y2_ax_r[0][i] <= y1_x_r[i];
        y2_ax_r[1][i] <= rnd_unit(y1_p_r[2*i] - y1_p_r[2*i+1]);
        y2_ax_r[2][i] <= y1_z_r[i];
      end
      y2_pos_r <= y1_pos_r;
    end
  end

  // translation column
  logic                 p_v_r, s_v_r;
  logic signed [W+1:0]  p_pr_r [3][3];
  logic signed [UW-1:0] p_ax_r [3][3];
  logic signed [UW-1:0] s_ax_r [3][3];
  logic signed [W-1:0]  s_c3_r [3];

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int r = 0; r < 3; r++) begin
        for (int i = 0; i < 3; i++) begin
          p_pr_r[r][i] <= sprod(y2_ax_r[r][i], y2_pos_r[i]);
        end
        s_c3_r[r] <= sat_w(-((W+4)'(p_pr_r[r][0]) + (W+4)'(p_pr_r[r][1])
                            + (W+4)'(p_pr_r[r][2])));
      end
      p_ax_r <= y2_ax_r;
      s_ax_r <= p_ax_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      c1_v_r <= 1'b0;
      c2_v_r <= 1'b0;
      y1_v_r <= 1'b0;
      y2_v_r <= 1'b0;
      p_v_r  <= 1'b0;
      s_v_r  <= 1'b0;
    end else if (adv) begin
      c1_v_r <= nz_v && nu_v;
      c2_v_r <= c1_v_r;
      y1_v_r <= nx_v;
      y2_v_r <= y1_v_r;
      p_v_r  <= y2_v_r;
      s_v_r  <= p_v_r;
    end
  end

  assign adv = !s_v_r || item_ready;

  lav_rows #(.COORD_WIDTH(W), .FRAC_BITS(F), .OUT_DW(OUT_DW)) u_rows (
    .clk(clk), .rst_n(rst_n),
    .item_valid(s_v_r), .item_ready(item_ready),
    .item_axis(s_ax_r), .item_col3(s_c3_r),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .out_tlast(out_tlast), .out_tuser(out_tuser)
  );

  a_last_on_view_row: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tlast == (out_tuser == ROW_Z)))
    else $error("tlast does not match the view row");

  a_rows_in_order: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tready && !out_tlast |=>
      out_tvalid && (out_tuser == $past(out_tuser) + 2'd1))
    else $error("rows out of order");

  a_full_pipe_holds: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready && s_v_r |-> !in_tready)
    else $error("input taken while pipeline is blocked");

endmodule
`default_nettype wire

[sim/lav_checker.sv]
// checker for the look-at view matrix block: watches both channels,
// predicts three rows per accepted input item and compares in order
// depends on lav_pkg
`timescale 1ns / 1ps
module lav_checker (
  input  wire         clk,
  input  wire         rst_n,
  input  wire         in_tvalid,
  input  wire         in_tready,
  input  wire [287:0] in_tdata,
  input  wire         out_tvalid,
  input  wire         out_tready,
  input  wire [87:0]  out_tdata,
  input  wire         out_tlast,
  input  wire [1:0]   out_tuser,
  output int          fail_count,
  output int          rows_pending,
  output int          rows_seen
);
  import lav_pkg::*;

  typedef struct packed {
    row_t        row;
    logic [17:0] c0;
    logic [17:0] c1;
    logic [17:0] c2;
    logic [31:0] c3;
    logic        last;
  } view_row_t;

  view_row_t row_queue[$];

  function automatic longint sat32(longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  function automatic longint abs64(longint v);
    return v < 0 ? -v : v;
  endfunction

  function automatic longint int_sqrt(longint n);
    longint root;
    longint bitv;
    root = 0;
    bitv = 64'sd1 << 62;
    while (bitv > n) bitv = bitv >>> 2;
    while (bitv != 0) begin
      if (n >= root + bitv) begin
        n = n - (root + bitv);
        root = (root >>> 1) + bitv;
      end else begin
        root = root >>> 1;
      end
      bitv = bitv >>> 2;
    end
    return root;
  endfunction

  // magnitudes up to 2^63 handled unsigned
  task automatic make_unit(input longint c[3], output longint u[3]);
    logic [63:0] m[3];
    logic [63:0] top;
    logic [63:0] sum;
    logic [63:0] len;
    logic [63:0] q;
    top = 0;
    for (int i = 0; i < 3; i++) begin
      m[i] = c[i] < 0 ? 64'd0 - 64'(c[i]) : 64'(c[i]);
      if (m[i] > top) top = m[i];
    end
    if (top == 0) begin
      u = '{0, 0, 0};
      return;
    end
    while (top >= (64'd1 << NORM_TOP)) begin
      top = top >> 1;
      for (int i = 0; i < 3; i++) m[i] = m[i] >> 1;
    end
    while (top < (64'd1 << (NORM_TOP - 1))) begin
      top = top << 1;
      for (int i = 0; i < 3; i++) m[i] = m[i] << 1;
    end
    sum = 0;
    for (int i = 0; i < 3; i++) sum += m[i] * m[i];
    len = 64'(int_sqrt(longint'(sum)));
    for (int i = 0; i < 3; i++) begin
      q = ((m[i] << 17) + len) / (2 * len);
      u[i] = c[i] < 0 ? -longint'(q) : longint'(q);
    end
  endtask

  function automatic longint round_unit(longint t);
    longint r;
    r = (abs64(t) + 32768) >>> 16;
    if (r > 65536) r = 65536;
    return t < 0 ? -r : r;
  endfunction

  function automatic longint axis_times_coord(longint a, longint p);
    longint ma;
    longint mp;
    longint r;
    ma = abs64(a);
    mp = abs64(p);
    r = ma * (mp >>> 16) + ((ma * (mp & 64'hffff) + 32768) >>> 16);
    return ((a < 0) != (p < 0)) ? -r : r;
  endfunction

  task automatic predict_matrix(input logic [287:0] d);
    longint pos[3], diff[3], up[3], upn[3], zax[3], xc[3], xax[3], yax[3];
    longint ax[3];
    longint dot;
    view_row_t r;
    for (int i = 0; i < 3; i++) begin
      pos[i] = longint'($signed(d[32*i +: 32]));
      diff[i] = sat32(pos[i] - longint'($signed(d[32*(i+3) +: 32])));
      up[i] = longint'($signed(d[32*(i+6) +: 32]));
    end
    make_unit(diff, zax);
    make_unit(up, upn);
    xc[0] = upn[1] * zax[2] - upn[2] * zax[1];
    xc[1] = upn[2] * zax[0] - upn[0] * zax[2];
    xc[2] = upn[0] * zax[1] - upn[1] * zax[0];
    make_unit(xc, xax);
    yax[0] = round_unit(zax[1] * xax[2] - zax[2] * xax[1]);
    yax[1] = round_unit(zax[2] * xax[0] - zax[0] * xax[2]);
    yax[2] = round_unit(zax[0] * xax[1] - zax[1] * xax[0]);
    for (int k = 0; k < 3; k++) begin
      for (int i = 0; i < 3; i++) ax[i] = k == 0 ? xax[i] : (k == 1 ? yax[i] : zax[i]);
      dot = 0;
      for (int i = 0; i < 3; i++) dot += axis_times_coord(ax[i], pos[i]);
      r.row = k == 0 ? ROW_X : (k == 1 ? ROW_Y : ROW_Z);
      r.c0 = ax[0][17:0];
      r.c1 = ax[1][17:0];
      r.c2 = ax[2][17:0];
      r.c3 = 32'(sat32(-dot));
      r.last = k == 2;
      row_queue.push_back(r);
    end
  endtask

  always @(posedge clk) begin
    view_row_t got;
    view_row_t want;
    if (!rst_n) begin
      fail_count <= 0;
      rows_seen <= 0;
    end else begin
      if (in_tvalid && in_tready) predict_matrix(in_tdata);
      if (out_tvalid && out_tready) begin
        got.row = out_tuser;
        got.c0 = out_tdata[17:0];
        got.c1 = out_tdata[35:18];
        got.c2 = out_tdata[53:36];
        got.c3 = out_tdata[85:54];
        got.last = out_tlast;
        rows_seen <= rows_seen + 1;
        if (row_queue.size() == 0) begin
          $display("%0t: unexpected row, actual %h", $time, got);
          fail_count <= fail_count + 1;
        end else begin
          want = row_queue.pop_front();
          if (got !== want) begin
            $display("%0t: row mismatch, expected %h actual %h", $time, want, got);
            fail_count <= fail_count + 1;
          end
        end
      end
    end
    rows_pending = row_queue.size();
  end
endmodule

[sim/tb.sv]
// testbench top for look_at_view_matrix: directed and random camera setups
// under several idling phases; depends on lav_pkg, lav_checker and the block
`timescale 1ns / 1ps
module tb;
  logic         clk;
  logic         rst_n;
  logic         in_tvalid;
  logic         in_tready;
  logic [287:0] in_tdata;
  logic         out_tvalid;
  logic         out_tready;
  logic [87:0]  out_tdata;
  logic         out_tlast;
  logic [1:0]   out_tuser;
  int           fail_count;
  int           rows_pending;
  int           rows_seen;
  int           cycle_count;
  int           stall_pct;
  int           items_sent;
  int           done;

  localparam int CYCLE_LIMIT = 400000;

  look_at_view_matrix i_dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .out_tlast(out_tlast), .out_tuser(out_tuser)
  );

  lav_checker i_checker (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .out_tlast(out_tlast), .out_tuser(out_tuser),
    .fail_count(fail_count), .rows_pending(rows_pending), .rows_seen(rows_seen)
  );

  initial clk = 0;
  always begin
    #1 clk = 1;
    #1 clk = 0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    out_tready <= ($urandom_range(99) >= stall_pct);
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("[look_at_view_matrix] ERROR");
      $finish;
    end
  end

  function automatic logic [31:0] rand_coord();
    case ($urandom_range(5))
      0: return 32'h7fffffff;
      1: return 32'h80000000;
      2: return 32'($signed($urandom_range(2000000)) - 1000000);
      3: return 32'($signed($urandom_range(64)) - 32);
      default: return $urandom;
    endcase
  endfunction

  // tvalid stays high between items unless the sender idles
  task automatic send_item(input logic [287:0] d, input int gap_pct);
    while ($urandom_range(99) < gap_pct) begin
      in_tvalid <= 0;
      @(posedge clk);
    end
    in_tvalid <= 1;
    in_tdata <= d;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    items_sent++;
  endtask

  function automatic logic [287:0] pack9(input logic [31:0] v[9]);
    logic [287:0] d;
    for (int i = 0; i < 9; i++) d[32*i +: 32] = v[i];
    return d;
  endfunction

  initial begin
    logic [31:0] v[9];
    int gap_pct;
    cycle_count = 0;
    stall_pct = 0;
    items_sent = 0;
    rst_n = 0;
    in_tvalid = 0;
    in_tdata = 0;
    out_tready = 1;
    repeat (3) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    // directed: ordinary view, position equals target, zero up, up parallel,
    // extremes of every field, saturated differences
    v = '{0, 0, 32'h50000, 0, 0, 0, 0, 32'h10000, 0};
    send_item(pack9(v), 0);
    v = '{32'h30000, 32'h20000, 32'h10000, 32'h30000, 32'h20000, 32'h10000,
          0, 32'h10000, 0};
    send_item(pack9(v), 0);
    v = '{0, 0, 32'h50000, 0, 0, 0, 0, 0, 0};
    send_item(pack9(v), 0);
    v = '{0, 32'h50000, 0, 0, 0, 0, 0, 32'h10000, 0};
    send_item(pack9(v), 0);
    v = '{32'h7fffffff, 32'h80000000, 32'h7fffffff, 32'h80000000, 32'h7fffffff,
          32'h80000000, 32'h7fffffff, 32'h80000000, 32'h7fffffff};
    send_item(pack9(v), 0);
    v = '{32'h80000000, 32'h7fffffff, 32'h80000000, 32'h7fffffff, 32'h80000000,
          32'h7fffffff, 32'h80000000, 32'h7fffffff, 32'h80000000};
    send_item(pack9(v), 0);
    v = '{32'hffffffff, 1, 32'hffffffff, 1, 32'hffffffff, 1, 1, 1, 32'hffffffff};
    send_item(pack9(v), 0);
    for (int i = 0; i < 9; i++) v[i] = 32'h7fffffff;
    send_item(pack9(v), 0);
    for (int i = 0; i < 9; i++) v[i] = 32'h80000000;
    send_item(pack9(v), 0);
    for (int i = 0; i < 9; i++) v[i] = 32'h80000000;
    v[0] = 0;
    send_item(pack9(v), 0);

    // pause with the pipeline drained
    in_tvalid <= 0;
    @(posedge clk);
    while (rows_pending != 0) @(posedge clk);

    for (int phase = 0; phase < 4; phase++) begin
      gap_pct = (phase == 1) ? 57 : (phase == 3 ? 35 : 0);
      stall_pct = (phase == 2) ? 57 : (phase == 3 ? 35 : 0);
      for (int n = 0; n < 125; n++) begin
        for (int i = 0; i < 9; i++) v[i] = rand_coord();
        // target equal to position now and then, up often axis aligned
        if ($urandom_range(9) == 0) for (int i = 0; i < 3; i++) v[3+i] = v[i];
        if ($urandom_range(3) == 0) begin
          v[6] = 0; v[7] = 32'h10000; v[8] = 0;
        end
        send_item(pack9(v), gap_pct);
      end
    end
    in_tvalid <= 0;
    stall_pct = 0;

    while (rows_pending != 0) @(posedge clk);
    repeat (200) @(posedge clk);
    $display("sent %0d camera setups, checked %0d rows across four idling phases",
             items_sent, rows_seen);
    if (fail_count == 0 && rows_pending == 0) begin
      $display("[look_at_view_matrix] OK");
    end else begin
      $display("[look_at_view_matrix] ERROR");
    end
    $finish;
  end
endmodule
